// ===== design/pos_pkg.sv =====
// Shared constants and types for the passage overlap suppression unit.
package pos_pkg;
   localparam int MaxRecordsDefault = 64;
   localparam int QueryW = 31;
   localparam int DocW = 32;
   localparam int RankW = 16;
   localparam int ScoreW = 32;
   localparam int StartW = 32;
   localparam int LenW = 20;
   localparam int KeepW = 7;
   localparam logic [KeepW-1:0] KeepReset = 7'd64;
   localparam int RecW = QueryW + DocW + RankW + ScoreW + StartW + LenW;

   typedef struct packed {
      logic [QueryW-1:0] query_id;
      logic [DocW-1:0] doc_id;
      logic [RankW-1:0] rank;
      logic signed [ScoreW-1:0] score;
      logic signed [StartW-1:0] start;
      logic [LenW-1:0] length;
   } rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // write the input record at the fill count
      logic drop;        // note an overflowed record
      logic clear_marks; // start of a new group
      logic read_a;      // read record i into the A register
      logic read_b;      // read record j
      logic compare;     // compare A with the record read last cycle
      logic read_out;    // read record i for output
      logic emit;        // present the record read last cycle
      logic emit_empty;  // present the empty marker
      logic last;        // this result ends the run
      logic finish;      // clear count and overflow flag
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic a_live;      // A register holds a comparable, undeleted record
      logic b_live;      // entry j is comparable and undeleted
      logic out_deleted; // entry i is deleted
   } sts_type;
endpackage

// ===== design/pos_ram.sv =====
// Generic RAM with one write port and one registered read port.
module pos_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/pos_datapath.sv =====
// Record store, deletion marks, pair comparison and result register.
module pos_datapath import pos_pkg::*; #(
   parameter int MaxRecords = MaxRecordsDefault,
   localparam int AW = $clog2(MaxRecords),
   localparam int CW = $clog2(MaxRecords + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [AW-1:0] idx_rd,
   input  rec_type       in_rec,
   output sts_type       sts,
   output logic [CW-1:0] count,
   output logic          rsp_valid,
   output rec_type       rsp_rec,
   output logic          rsp_empty,
   output logic          rsp_overflow,
   output logic          rsp_last
);
   rec_type rd_data;
   rec_type a_ff, a_in;
   logic [AW-1:0] a_idx_ff, b_idx_ff;
   logic [MaxRecords-1:0] del_ff, del_in;
   logic [CW-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic cmp_ff, emit_ff, last_ff;
   logic rvalid_ff, rvalid_in, rempty_ff, rempty_in, rovf_ff, rovf_in, rlast_ff, rlast_in;
   rec_type rrec_ff, rrec_in;
   logic signed [StartW+1:0] a_end, b_end, a_st, b_st;
   logic meet, b_ok;

   pos_ram #(.Width(RecW), .Depth(MaxRecords)) u_store (
      .clock(clock), .wr_en(cmd.load), .wr_addr(count_ff[AW-1:0]),
      .wr_data(in_rec), .rd_addr(idx_rd), .rd_data(rd_data)
   );

   assign a_st = {{2{a_ff.start[StartW-1]}}, a_ff.start};
   assign b_st = {{2{rd_data.start[StartW-1]}}, rd_data.start};
   assign a_end = a_st + $signed({{(StartW+2-LenW){1'b0}}, a_ff.length}) - 1;
   assign b_end = b_st + $signed({{(StartW+2-LenW){1'b0}}, rd_data.length}) - 1;
   assign meet = (a_st >= b_st && a_end <= b_end) || (a_st <= b_st && a_end >= b_end)
      || (b_st >= a_st && b_st <= a_end) || (b_end >= a_st && b_end <= a_end);
   assign b_ok = !rd_data.start[StartW-1] && !del_ff[b_idx_ff];

   assign sts.full = count_ff == CW'(MaxRecords);
   assign sts.a_live = !a_ff.start[StartW-1] && !del_ff[a_idx_ff];
   assign sts.b_live = b_ok;
   assign sts.out_deleted = del_ff[b_idx_ff];
   assign count = count_ff;

   always_comb begin
      a_in = a_ff;
      del_in = del_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      rvalid_in = 1'b0;
      rempty_in = 1'b0;
      rovf_in = ovf_ff;
      rlast_in = 1'b0;
      rrec_in = rrec_ff;
      if (cmd.clear_marks) del_in = '0;
      if (cmd.load) count_in = count_ff + CW'(1);
      if (cmd.drop) ovf_in = 1'b1;
      if (cmp_ff) a_in = rd_data;
      // A pair is resolved in the cycle after its B record is read.
      if (cmd.compare && b_ok && !a_ff.start[StartW-1]
          && a_ff.doc_id == rd_data.doc_id && meet) begin
         if (a_ff.score < rd_data.score) del_in[a_idx_ff] = 1'b1;
         else del_in[b_idx_ff] = 1'b1;
      end
      if (emit_ff) begin
         rvalid_in = 1'b1;
         rrec_in = rd_data;
         rlast_in = last_ff;
      end
      if (cmd.emit_empty) begin
         rvalid_in = 1'b1;
         rempty_in = 1'b1;
         rrec_in = '0;
         rlast_in = 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         del_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         cmp_ff <= 1'b0;
         emit_ff <= 1'b0;
      end else begin
         del_ff <= del_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rvalid_ff <= rvalid_in;
         cmp_ff <= cmd.read_a;
         emit_ff <= cmd.emit;
      end
      a_ff <= a_in;
      if (cmd.read_a) a_idx_ff <= idx_rd;
      if (cmd.read_b || cmd.read_out) b_idx_ff <= idx_rd;
      last_ff <= cmd.last;
      rempty_ff <= rempty_in;
      rovf_ff <= rovf_in;
      rlast_ff <= rlast_in;
      rrec_ff <= rrec_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_rec = rrec_ff;
   assign rsp_empty = rempty_ff;
   assign rsp_overflow = rovf_ff;
   assign rsp_last = rlast_ff;
endmodule

// ===== design/pos_ctrl.sv =====
// Controller sequencing load, pairwise suppression and output.
module pos_ctrl import pos_pkg::*; #(
   parameter int MaxRecords = MaxRecordsDefault,
   localparam int AW = $clog2(MaxRecords),
   localparam int CW = $clog2(MaxRecords + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             last_in_group,
   input  logic [KeepW-1:0] keep_count,
   input  sts_type          sts,
   input  logic [CW-1:0]    count,
   output cmd_type          cmd,
   output logic [AW-1:0]    idx_rd,
   output logic             busy
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDA   = 7'b0000010,
      S_WAITA = 7'b0000100,
      S_PAIR  = 7'b0001000,
      S_DRAIN = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, lim_ff, lim_in;
   logic pend_ff, pend_in, any_ff, any_in, chk_ff, chk_in;
   logic [CW-1:0] nxt_j;

   assign busy = state_ff != S_IDLE;
   assign nxt_j = (j_ff + CW'(1) == i_ff) ? j_ff + CW'(2) : j_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      lim_in = lim_ff;
      pend_in = 1'b0;
      any_in = any_ff;
      chk_in = 1'b0;
      cmd = '0;
      idx_rd = i_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            cmd.clear_marks = count == '0;
            if (start) begin
               if (sts.full) cmd.drop = 1'b1;
               else cmd.load = 1'b1;
               if (last_in_group) begin
                  state_in = S_RDA;
                  i_in = '0;
               end
            end
         end
         S_RDA: begin
            // Start the sweep of record i, or move on to output.
            if (i_ff >= count) begin
               state_in = S_OUT;
               i_in = '0;
               any_in = 1'b0;
               lim_in = (CW'(keep_count) < count) ? CW'(keep_count) : count;
            end else begin
               cmd.read_a = 1'b1;
               state_in = S_WAITA;
            end
         end
         S_WAITA: begin
            state_in = S_PAIR;
            j_in = (i_ff == '0) ? CW'(1) : '0;
         end
         S_PAIR: begin
            // A is loaded; status a_live judges the whole sweep.
            cmd.compare = pend_ff;
            if (!sts.a_live && !pend_ff) begin
               i_in = i_ff + CW'(1);
               state_in = S_RDA;
            end else if (j_ff >= count) begin
               state_in = pend_ff ? S_DRAIN : S_RDA;
               if (!pend_ff) i_in = i_ff + CW'(1);
            end else begin
               idx_rd = j_ff[AW-1:0];
               cmd.read_b = 1'b1;
               pend_in = 1'b1;
               j_in = nxt_j;
            end
         end
         S_DRAIN: begin
            i_in = i_ff + CW'(1);
            state_in = S_RDA;
         end
         S_OUT: begin
            // Read entry i, check its mark next cycle, emit if kept.
            if (chk_ff && !sts.out_deleted) any_in = 1'b1;
            if (i_ff < lim_ff && !chk_ff) begin
               cmd.read_out = 1'b1;
               chk_in = 1'b1;
            end else if (chk_ff) begin
               i_in = i_ff + CW'(1);
               if (!sts.out_deleted) begin
                  cmd.emit = 1'b1;
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!any_ff) cmd.emit_empty = 1'b1;
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= 1'b0;
         chk_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         chk_ff <= chk_in;
         any_ff <= any_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      lim_ff <= lim_in;
   end
endmodule

// ===== design/passage_overlap_suppression_unit.sv =====
// Top level of the passage overlap suppression unit.
//
//  channel   direction  handshake                   payload
//  req_      in         start & !busy               one passage record
//  rsp_      out        rsp_valid strobe, 1 cycle   kept record or empty marker
//  csr_      in         csr_write_enable            keep_count
//
// A record that does not end its group is taken without raising busy. A record that ends
// the group starts a pairwise sweep that reads each of the N stored records
// once as the reference and, when that reference is live, every other record
// from the single store read port, followed by one output pass over the
// considered records. busy is high for the whole sweep and output pass.
// Reset is synchronous and clears the count, marks and overflow flag.
// Results cannot be stalled: each stands for exactly one cycle.
//
// The last result of a run is not known to be last when emitted ahead of
// a final empty check, so the run always closes with a result carrying
// rsp_last_of_run; to keep that exact, kept records are held back by one
// and the closing transaction is the final kept record, or the empty marker when none is kept.
module passage_overlap_suppression_unit import pos_pkg::*; #(
   parameter int MaxRecords = MaxRecordsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [QueryW-1:0]        req_query_id,
   input  logic [DocW-1:0]          req_doc_id,
   input  logic [RankW-1:0]         req_rank,
   input  logic signed [ScoreW-1:0] req_score,
   input  logic signed [StartW-1:0] req_passage_start,
   input  logic [LenW-1:0]          req_passage_length,
   input  logic                     req_last_in_group,
   input  logic                     csr_write_enable,
   input  logic [KeepW-1:0]         csr_write_data,
   output logic                     rsp_valid,
   output logic [QueryW-1:0]        rsp_out_query_id,
   output logic [DocW-1:0]          rsp_out_doc_id,
   output logic [RankW-1:0]         rsp_out_rank,
   output logic signed [ScoreW-1:0] rsp_out_score,
   output logic signed [StartW-1:0] rsp_out_start,
   output logic [LenW-1:0]          rsp_out_length,
   output logic                     rsp_empty_group,
   output logic                     rsp_overflowed,
   output logic                     rsp_last_of_run
);
   localparam int AW = $clog2(MaxRecords);
   localparam int CW = $clog2(MaxRecords + 1);

   cmd_type cmd;
   sts_type sts;
   logic [AW-1:0] idx_rd;
   logic [CW-1:0] count;
   logic [KeepW-1:0] keep_ff;
   rec_type in_rec, dp_rec;
   logic dp_valid, dp_empty, dp_ovf, dp_last, fin_d;
   // Holding register: one kept record waits until the next one, or the
   // end of the pass, shows whether it closes the run.
   logic hold_v_ff;
   rec_type hold_rec_ff;
   logic hold_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) keep_ff <= KeepReset;
      else if (csr_write_enable) keep_ff <= csr_write_data;
   end

   assign in_rec = '{req_query_id, req_doc_id, req_rank, req_score,
                     req_passage_start, req_passage_length};

   pos_ctrl #(.MaxRecords(MaxRecords)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .last_in_group(req_last_in_group),
      .keep_count(keep_ff), .sts(sts), .count(count), .cmd(cmd),
      .idx_rd(idx_rd), .busy(busy)
   );

   pos_datapath #(.MaxRecords(MaxRecords)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .idx_rd(idx_rd), .in_rec(in_rec), .sts(sts), .count(count),
      .rsp_valid(dp_valid), .rsp_rec(dp_rec), .rsp_empty(dp_empty),
      .rsp_overflow(dp_ovf), .rsp_last(dp_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         fin_d <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         fin_d <= cmd.finish;
         rsp_valid <= 1'b0;
         if (dp_valid && !dp_empty) begin
            if (hold_v_ff) rsp_valid <= 1'b1;
            hold_v_ff <= 1'b1;
         end else if (dp_valid && dp_empty) begin
            rsp_valid <= 1'b1;
         end else if (fin_d && hold_v_ff) begin
            rsp_valid <= 1'b1;
            hold_v_ff <= 1'b0;
         end
      end
      if (dp_valid && !dp_empty) begin
         hold_rec_ff <= dp_rec;
         hold_ovf_ff <= dp_ovf;
      end
      if (dp_valid && dp_empty) begin
         {rsp_out_query_id, rsp_out_doc_id, rsp_out_rank, rsp_out_score,
          rsp_out_start, rsp_out_length} <= dp_rec;
         rsp_empty_group <= 1'b1;
         rsp_overflowed <= dp_ovf;
         rsp_last_of_run <= dp_last;
      end else begin
         {rsp_out_query_id, rsp_out_doc_id, rsp_out_rank, rsp_out_score,
          rsp_out_start, rsp_out_length} <= hold_rec_ff;
         rsp_empty_group <= 1'b0;
         rsp_overflowed <= hold_ovf_ff;
         rsp_last_of_run <= !(dp_valid && !dp_empty);
      end
   end
endmodule

// ===== design/pos_checker.sv =====
// Port-level checker for the passage overlap suppression unit.
module pos_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_in_group,
   input logic rsp_valid,
   input logic rsp_empty_group,
   input logic rsp_last_of_run
);
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_group |-> rsp_last_of_run) else $error("empty not last");
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_in_group |=> busy) else $error("no flush");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) && !$past(busy, 2) && !$past(busy, 3) |-> !rsp_valid)
      else $error("result while idle");
   a_end_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !rsp_valid) else $error("result after last");
endmodule

bind passage_overlap_suppression_unit pos_checker u_pos_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_last_in_group(req_last_in_group), .rsp_valid(rsp_valid),
   .rsp_empty_group(rsp_empty_group), .rsp_last_of_run(rsp_last_of_run)
);

// ===== tb/testbench.sv =====
// Testbench for the passage overlap suppression unit: random and directed groups checked against a predictor.
module testbench;
   import pos_pkg::*;

   // One result as the block should present it: either a kept record or the
   // empty marker, with the overflow and end-of-run flags.
   typedef struct {
      rec_type rec;
      logic    empty_group;
      logic    overflowed;
      logic    last_of_run;
   } kept_result_type;

   // The scoreboard keeps its own copy of the record store, the deletion
   // marks and keep_count. A transaction that closes a group runs the
   // suppression sweep and queues every result that the group should produce.
   class scoreboard_type;
      rec_type         group_records[64];
      bit              deleted[64];
      int              stored;
      bit              dropped_any;
      int              keep;
      kept_result_type results_due[$];
      int              failures;

      function new();
         stored = 0;
         dropped_any = 0;
         keep = 64;
         failures = 0;
      endfunction

      function bit overlaps(rec_type a, rec_type b);
         longint a_lo, a_hi, b_lo, b_hi;
         a_lo = longint'($signed(a.start));
         a_hi = a_lo + longint'(a.length) - 1;
         b_lo = longint'($signed(b.start));
         b_hi = b_lo + longint'(b.length) - 1;
         // The test is taken literally, so a zero length interval can
         // still meet another one through the containment terms.
         return (a_lo >= b_lo && a_hi <= b_hi) || (a_lo <= b_lo && a_hi >= b_hi)
            || (b_lo >= a_lo && b_lo <= a_hi) || (b_hi >= a_lo && b_hi <= a_hi);
      endfunction

      function void note_record(rec_type r, bit last);
         int n, produced;
         kept_result_type k;
         if (stored < 64) begin
            group_records[stored] = r;
            deleted[stored] = 0;
            stored++;
         end else begin
            dropped_any = 1;
         end
         if (!last) return;
         // Pairwise sweep in load order. A record deleted during its own
         // sweep still goes on comparing against later records.
         for (int i = 0; i < stored; i++) begin
            if ($signed(group_records[i].start) < 0 || deleted[i]) continue;
            for (int j = 0; j < stored; j++) begin
               if (i == j) continue;
               if ($signed(group_records[j].start) < 0 || deleted[j]) continue;
               if (group_records[i].doc_id != group_records[j].doc_id) continue;
               if (overlaps(group_records[i], group_records[j])) begin
                  if ($signed(group_records[i].score) < $signed(group_records[j].score))
                     deleted[i] = 1;
                  else
                     deleted[j] = 1;
               end
            end
         end
         n = (keep < stored) ? keep : stored;
         produced = 0;
         for (int i = 0; i < n; i++) begin
            if (deleted[i]) continue;
            k.rec = group_records[i];
            k.empty_group = 0;
            k.overflowed = dropped_any;
            k.last_of_run = 0;
            results_due.push_back(k);
            produced++;
         end
         if (produced == 0) begin
            k.rec = '0;
            k.empty_group = 1;
            k.overflowed = dropped_any;
            k.last_of_run = 1;
            results_due.push_back(k);
         end else begin
            results_due[results_due.size() - 1].last_of_run = 1;
         end
         stored = 0;
         dropped_any = 0;
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(kept_result_type got);
         kept_result_type want;
         if (results_due.size() == 0) begin
            $display("%0t: result with none expected, doc %h rank %h", $time,
               got.rec.doc_id, got.rec.rank);
            failures++;
            return;
         end
         want = results_due.pop_front();
         compare_field("query_id", 64'(want.rec.query_id), 64'(got.rec.query_id));
         compare_field("doc_id", 64'(want.rec.doc_id), 64'(got.rec.doc_id));
         compare_field("rank", 64'(want.rec.rank), 64'(got.rec.rank));
         compare_field("score", 64'($unsigned(want.rec.score)),
            64'($unsigned(got.rec.score)));
         compare_field("start", 64'($unsigned(want.rec.start)),
            64'($unsigned(got.rec.start)));
         compare_field("length", 64'(want.rec.length), 64'(got.rec.length));
         compare_field("empty_group", 64'(want.empty_group), 64'(got.empty_group));
         compare_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
         compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [QueryW-1:0] req_query_id = '0;
   logic [DocW-1:0] req_doc_id = '0;
   logic [RankW-1:0] req_rank = '0;
   logic signed [ScoreW-1:0] req_score = '0;
   logic signed [StartW-1:0] req_passage_start = '0;
   logic [LenW-1:0] req_passage_length = '0;
   logic req_last_in_group = 0;
   logic csr_write_enable = 0;
   logic [KeepW-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic [QueryW-1:0] rsp_out_query_id;
   logic [DocW-1:0] rsp_out_doc_id;
   logic [RankW-1:0] rsp_out_rank;
   logic signed [ScoreW-1:0] rsp_out_score;
   logic signed [StartW-1:0] rsp_out_start;
   logic [LenW-1:0] rsp_out_length;
   logic rsp_empty_group;
   logic rsp_overflowed;
   logic rsp_last_of_run;

   scoreboard_type board = new();
   int items_sent = 0;
   longint cycles = 0;
   localparam longint CycleLimit = 3000000;

   passage_overlap_suppression_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_query_id(req_query_id), .req_doc_id(req_doc_id), .req_rank(req_rank),
      .req_score(req_score), .req_passage_start(req_passage_start),
      .req_passage_length(req_passage_length), .req_last_in_group(req_last_in_group),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_out_query_id(rsp_out_query_id),
      .rsp_out_doc_id(rsp_out_doc_id), .rsp_out_rank(rsp_out_rank),
      .rsp_out_score(rsp_out_score), .rsp_out_start(rsp_out_start),
      .rsp_out_length(rsp_out_length), .rsp_empty_group(rsp_empty_group),
      .rsp_overflowed(rsp_overflowed), .rsp_last_of_run(rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // The cycle counter guards against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Results cannot be held off, so every strobed cycle is one transaction.
   // Outputs are sampled at the edge, before the block updates them.
   always @(posedge clock) begin
      kept_result_type got;
      if (!reset && rsp_valid) begin
         got.rec.query_id = rsp_out_query_id;
         got.rec.doc_id = rsp_out_doc_id;
         got.rec.rank = rsp_out_rank;
         got.rec.score = rsp_out_score;
         got.rec.start = rsp_out_start;
         got.rec.length = rsp_out_length;
         got.empty_group = rsp_empty_group;
         got.overflowed = rsp_overflowed;
         got.last_of_run = rsp_last_of_run;
         board.check_result(got);
      end
   end

   // Presents one record and holds it until an edge at which the block is
   // not busy. start stays high afterwards so that a following record can be
   // driven straight away; an idle burst lowers it first.
   task automatic send_record(rec_type r, bit last, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start <= 1;
      req_query_id <= r.query_id;
      req_doc_id <= r.doc_id;
      req_rank <= r.rank;
      req_score <= r.score;
      req_passage_start <= r.start;
      req_passage_length <= r.length;
      req_last_in_group <= last;
      do @(posedge clock); while (busy);
      board.note_record(r, last);
      items_sent++;
   endtask

   // Waits until every expected result has come and the block is quiet,
   // then lets a few more cycles pass, since a record that closes nothing
   // may still be in flight.
   task automatic wait_quiet();
      start <= 0;
      do @(posedge clock); while (board.results_due.size() != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_keep(int value);
      wait_quiet();
      csr_write_enable <= 1;
      csr_write_data <= value[KeepW-1:0];
      @(posedge clock);
      csr_write_enable <= 0;
      board.keep = value;
   endtask

   // Random record content: a few documents and short nearby intervals make
   // overlaps common, with some negative starts, zero lengths, tied scores
   // and fully random fields so that every bit is exercised.
   function automatic rec_type random_record();
      rec_type r;
      r.query_id = QueryW'($urandom);
      r.rank = RankW'($urandom);
      r.doc_id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0: r.start = -$signed({1'b0, 31'($urandom)}) - 1;
         1: r.start = $urandom;
         default: r.start = $urandom_range(0, 60);
      endcase
      case ($urandom_range(0, 9))
         0: r.length = '0;
         1: r.length = LenW'($urandom);
         default: r.length = LenW'($urandom_range(1, 12));
      endcase
      r.score = ($urandom_range(0, 2) == 0) ? $urandom : $signed($urandom_range(0, 6)) - 3;
      return r;
   endfunction

   task automatic send_group(int size, bit gaps);
      for (int i = 0; i < size; i++)
         send_record(random_record(), i == size - 1, gaps);
   endtask

   function automatic rec_type make_record(int doc, int first, int len, int sc);
      rec_type r;
      r.query_id = 31'd7;
      r.doc_id = doc;
      r.rank = 16'(items_sent);
      r.start = first;
      r.length = LenW'(len);
      r.score = sc;
      return r;
   endfunction

   initial begin
      rec_type r;
      int size;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: a tie deletes the second record of the pair, a negative
      // start is left alone, and a zero length record sits inside another.
      send_record(make_record(1, 10, 5, 100), 0, 0);
      send_record(make_record(1, 12, 5, 100), 0, 0);
      send_record(make_record(1, -5, 40, 900), 0, 0);
      send_record(make_record(1, 11, 0, 50), 0, 0);
      send_record(make_record(2, 0, 1, -2), 1, 0);
      // A chain in which the middle record deletes the first record and then
      // also goes on deleting a weaker later record.
      send_record(make_record(3, 0, 10, 5), 0, 0);
      send_record(make_record(3, 9, 10, 9), 0, 0);
      send_record(make_record(3, 18, 4, 1), 1, 0);
      // Extreme field values and a lone record closing its group.
      r.query_id = '1; r.doc_id = '1; r.rank = '1; r.score = 32'sh7fffffff;
      r.start = 32'sh7fffffff; r.length = '1;
      send_record(r, 0, 0);
      r.score = 32'sh80000000; r.start = 32'sh7ffff000; r.length = '0;
      send_record(r, 1, 0);
      send_record(make_record(4, 0, 0, 0), 1, 0);

      // With only one record considered and that one beaten, only the empty
      // marker should come out.
      write_keep(1);
      send_record(make_record(5, 0, 8, 1), 0, 0);
      send_record(make_record(5, 4, 8, 2), 1, 0);

      // A group larger than the store: the closing record is itself dropped
      // and every result carries the overflow flag.
      write_keep(64);
      send_group(70, 0);

      // The sender holds back here until the block has drained completely.
      wait_quiet();

      while (items_sent < 180) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: write_keep(1);
               1: write_keep(64);
               default: write_keep($urandom_range(1, 64));
            endcase
         end
         size = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
         send_group(size, items_sent < 150);
      end

      start <= 0;
      do @(posedge clock); while (board.results_due.size() != 0 || busy);
      repeat (50) @(posedge clock);
      if (board.failures == 0 && board.results_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
